>>> design/tick_deadline_queue_core_assert.svh
// ----------------------------------------------------------------------------
// Tick deadline queue assertion macros
// Shared property wrappers for the queue's checker.
// ----------------------------------------------------------------------------
`ifndef TICK_DEADLINE_QUEUE_CORE_ASSERT_SVH
`define TICK_DEADLINE_QUEUE_CORE_ASSERT_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define TDQ_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tick deadline queue: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define TDQ_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tick deadline queue: next-cycle check failed");

`endif

>>> design/tdq_pkg.sv
// ----------------------------------------------------------------------------
// Tick deadline queue package
// Codes, widths and defaults shared by the queue core and its checker.
// ----------------------------------------------------------------------------
package tdq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int DEFAULT_ID_BITS     = 8;
    localparam int MAX_RESULTS         = 16;

    localparam int TICK_W   = 32;
    localparam int FUNC_W   = 2;
    localparam int STATUS_W = 3;
    localparam int HID_W    = 8;

    // Slave tdata: delay_ticks, handler_id.
    localparam int S_TDATA_W = 40;
    // Master tdata: fired_id.
    localparam int M_TDATA_W = 8;

    typedef logic [FUNC_W-1:0]   func_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam func_t FUNC_REGISTER = 2'd0;
    localparam func_t FUNC_TICK     = 2'd1;
    localparam func_t FUNC_CLEAR    = 2'd2;
    localparam func_t FUNC_RSVD     = 2'd3;

    localparam status_t STATUS_REGISTERED = 3'd0;
    localparam status_t STATUS_FULL       = 3'd1;
    localparam status_t STATUS_FIRED      = 3'd2;
    localparam status_t STATUS_IDLE_TICK  = 3'd3;
    localparam status_t STATUS_CLEARED    = 3'd4;

endpackage

>>> design/tick_deadline_queue_core.sv
// A register moves later entries aside one by one, then writes the new entry; a tick
// pops expired entries one by one (at most 16), then sends its final result; a clear
// or a rejected register goes straight to its result; a reserved code is dropped.
// The final result becomes valid in the cycle s_tready returns.
// One transaction at a time, paced by the single compare unit and one memory read.
// Reset clears the counter, queue count and sequencer; queue memory is not swept.
// ----------------------------------------------------------------------------
// Tick deadline queue core
// One-shot timer queue kept sorted by deadline in a circular memory.
// ----------------------------------------------------------------------------
module tick_deadline_queue_core #(
    parameter int QUEUE_DEPTH = tdq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ID_BITS     = tdq_pkg::DEFAULT_ID_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [31:0] delay_ticks, [39:32] handler_id
    input  logic [tdq_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] func
    input  logic [tdq_pkg::FUNC_W-1:0]    s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] fired_id
    output logic [tdq_pkg::M_TDATA_W-1:0] m_tdata,
    // [2:0] status
    output logic [tdq_pkg::STATUS_W-1:0]  m_tuser,
    output logic                          m_tlast
);
    import tdq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int NF_W  = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INS_RD,
        ST_INS_CMP,
        ST_TK_RD,
        ST_TK_CMP,
        ST_TK_FIN,
        ST_RESP
    } state_t;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [TICK_W-1:0]   tick_reg, tick_next;
    logic [TICK_W-1:0]   dl_reg, dl_next;
    logic [ID_BITS-1:0]  nid_reg, nid_next;
    logic [CNT_W-1:0]    idx_reg, idx_next;
    logic [NF_W-1:0]     nfire_reg, nfire_next;
    logic                pend_reg, pend_next;
    logic [ID_BITS-1:0]  pend_id_reg, pend_id_next;
    status_t             resp_reg, resp_next;
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [HID_W-1:0]    out_id_reg, out_id_next;
    logic                out_last_reg, out_last_next;

    logic [TICK_W-1:0]   mem_dl [QUEUE_DEPTH];
    logic [ID_BITS-1:0]  mem_id [QUEUE_DEPTH];
    logic [TICK_W-1:0]   rd_dl_reg;
    logic [ID_BITS-1:0]  rd_id_reg;
    logic [IDX_W-1:0]    rd_addr;
    logic                wr_en;
    logic [IDX_W-1:0]    wr_addr;
    logic [TICK_W-1:0]   wr_dl;
    logic [ID_BITS-1:0]  wr_id;
    logic                out_free;
    logic [TICK_W-1:0]   in_delay;
    logic [HID_W-1:0]    in_hid;

    // Logical queue offset to physical memory address, wrapping at the depth.
    function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] head,
                                              input logic [IDX_W-1:0] off);
        logic [IDX_W:0] sum;
        sum = {1'b0, head} + {1'b0, off};
        if (sum >= (IDX_W+1)'(QUEUE_DEPTH)) begin
            sum = sum - (IDX_W+1)'(QUEUE_DEPTH);
        end
        return sum[IDX_W-1:0];
    endfunction

    assign in_delay = s_tdata[TICK_W-1:0];
    assign in_hid   = s_tdata[TICK_W+HID_W-1:TICK_W];
    assign out_free = !out_valid_reg || m_tready;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_id_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        head_next       = head_reg;
        tick_next       = tick_reg;
        dl_next         = dl_reg;
        nid_next        = nid_reg;
        idx_next        = idx_reg;
        nfire_next      = nfire_reg;
        pend_next       = pend_reg;
        pend_id_next    = pend_id_reg;
        resp_next       = resp_reg;
        out_valid_next  = out_valid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_last_next   = out_last_reg;
        rd_addr         = head_reg;
        wr_en           = 1'b0;
        wr_addr         = phys(head_reg, idx_reg[IDX_W-1:0]);
        wr_dl           = dl_reg;
        wr_id           = nid_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    case (s_tuser)
                        FUNC_REGISTER:
                        begin
                            if (count_reg == CNT_W'(QUEUE_DEPTH))
                            begin
                                resp_next  = STATUS_FULL;
                                state_next = ST_RESP;
                            end
                            else
                            begin
                                dl_next    = tick_reg + in_delay;
                                nid_next   = ID_BITS'(in_hid);
                                idx_next   = count_reg;
                                state_next = ST_INS_RD;
                            end
                        end
                        FUNC_TICK:
                        begin
                            tick_next  = tick_reg + 1'b1;
                            nfire_next = '0;
                            pend_next  = 1'b0;
                            state_next = ST_TK_RD;
                        end
                        FUNC_CLEAR:
                        begin
                            count_next = '0;
                            resp_next  = STATUS_CLEARED;
                            state_next = ST_RESP;
                        end
                        default:
                        begin
                            state_next = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_INS_RD:
            begin
                if (idx_reg == '0)
                begin
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    resp_next  = STATUS_REGISTERED;
                    state_next = ST_RESP;
                end
                else
                begin
                    rd_addr    = phys(head_reg, idx_reg[IDX_W-1:0] - 1'b1);
                    state_next = ST_INS_CMP;
                end
            end
            ST_INS_CMP:
            begin
                wr_en = 1'b1;
                if (rd_dl_reg <= dl_reg)
                begin
                    // Equal deadlines keep arrival order: the new entry goes behind.
                    count_next = count_reg + 1'b1;
                    resp_next  = STATUS_REGISTERED;
                    state_next = ST_RESP;
                end
                else
                begin
                    wr_dl      = rd_dl_reg;
                    wr_id      = rd_id_reg;
                    idx_next   = idx_reg - 1'b1;
                    state_next = ST_INS_RD;
                end
            end
            ST_TK_RD:
            begin
                if (count_reg == '0 || nfire_reg == NF_W'(MAX_RESULTS))
                begin
                    state_next = ST_TK_FIN;
                end
                else
                begin
                    state_next = ST_TK_CMP;
                end
            end
            ST_TK_CMP:
            begin
                if (rd_dl_reg <= tick_reg)
                begin
                    // The previous expired entry is sent only once we know another follows.
                    if (!pend_reg || out_free)
                    begin
                        if (pend_reg)
                        begin
                            out_valid_next  = 1'b1;
                            out_status_next = STATUS_FIRED;
                            out_id_next     = HID_W'(pend_id_reg);
                            out_last_next   = 1'b0;
                        end
                        pend_next    = 1'b1;
                        pend_id_next = rd_id_reg;
                        head_next    = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                           : head_reg + 1'b1;
                        count_next   = count_reg - 1'b1;
                        nfire_next   = nfire_reg + 1'b1;
                        state_next   = ST_TK_RD;
                    end
                end
                else
                begin
                    state_next = ST_TK_FIN;
                end
            end
            ST_TK_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = pend_reg ? STATUS_FIRED : STATUS_IDLE_TICK;
                    out_id_next     = pend_reg ? HID_W'(pend_id_reg) : '0;
                    out_last_next   = 1'b1;
                    if (count_reg == '0)
                    begin
                        tick_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = resp_reg;
                    out_id_next     = '0;
                    out_last_next   = 1'b1;
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            count_reg      <= '0;
            head_reg       <= '0;
            tick_reg       <= '0;
            dl_reg         <= '0;
            nid_reg        <= '0;
            idx_reg        <= '0;
            nfire_reg      <= '0;
            pend_reg       <= 1'b0;
            pend_id_reg    <= '0;
            resp_reg       <= STATUS_REGISTERED;
            out_valid_reg  <= 1'b0;
            out_status_reg <= STATUS_REGISTERED;
            out_id_reg     <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            count_reg      <= count_next;
            head_reg       <= head_next;
            tick_reg       <= tick_next;
            dl_reg         <= dl_next;
            nid_reg        <= nid_next;
            idx_reg        <= idx_next;
            nfire_reg      <= nfire_next;
            pend_reg       <= pend_next;
            pend_id_reg    <= pend_id_next;
            resp_reg       <= resp_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_id_reg     <= out_id_next;
            out_last_reg   <= out_last_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_dl[wr_addr] <= wr_dl;
            mem_id[wr_addr] <= wr_id;
        end
        rd_dl_reg <= mem_dl[rd_addr];
        rd_id_reg <= mem_id[rd_addr];
    end

endmodule

>>> design/tick_deadline_queue_core_checker.sv
// ----------------------------------------------------------------------------
// Tick deadline queue checker
// Port-level properties of the queue core, attached by bind.
// ----------------------------------------------------------------------------
`include "tick_deadline_queue_core_assert.svh"

module tdq_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [tdq_pkg::FUNC_W-1:0]    s_tuser,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [tdq_pkg::M_TDATA_W-1:0] m_tdata,
    input logic [tdq_pkg::STATUS_W-1:0]  m_tuser,
    input logic                          m_tlast
);
    import tdq_pkg::*;

    // A stalled result holds.
    `TDQ_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready,
                     m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))

    // Every status shown is one of the defined codes.
    `TDQ_ASSERT_NOW(a_status_code, m_tvalid, m_tuser <= STATUS_CLEARED)

    // Only fired results carry an id or may leave the transaction open.
    `TDQ_ASSERT_NOW(a_non_fired_final, m_tvalid && m_tuser != STATUS_FIRED,
                    m_tlast && m_tdata == '0)

    // A real command keeps the sequencer busy for at least the following cycle.
    `TDQ_ASSERT_NEXT(a_busy_after_cmd, s_tvalid && s_tready && s_tuser != FUNC_RSVD,
                     !s_tready)

endmodule

bind tick_deadline_queue_core tdq_checker u_tdq_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

>>> tb/tick_deadline_queue_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tick deadline queue checker
// Watches both stream channels, keeps its own copy of the timer queue to
// predict the results of every accepted transaction, and compares each
// result the block hands out against the oldest prediction.
// ----------------------------------------------------------------------------
module tick_deadline_queue_checker #(
    parameter int QUEUE_DEPTH = tdq_pkg::DEFAULT_QUEUE_DEPTH,
    parameter int ID_BITS     = tdq_pkg::DEFAULT_ID_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // [31:0] delay_ticks, [39:32] handler_id
    input  logic [tdq_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] func
    input  logic [tdq_pkg::FUNC_W-1:0]    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // [7:0] fired_id
    input  logic [tdq_pkg::M_TDATA_W-1:0] m_tdata,
    // [2:0] status
    input  logic [tdq_pkg::STATUS_W-1:0]  m_tuser,
    input  logic                          m_tlast,
    output int                            fail_count,
    output int                            pending
);

    import tdq_pkg::*;

    typedef struct packed {
        status_t                status;
        logic [M_TDATA_W-1:0]   fired_id;
        logic                   last;
    } timer_result_t;

    timer_result_t        expected_results[$];
    logic [TICK_W-1:0]    tick_now;
    logic [TICK_W-1:0]    deadlines [QUEUE_DEPTH];
    logic [ID_BITS-1:0]   handler_ids [QUEUE_DEPTH];
    int unsigned          entries;
    int                   errors;

    assign fail_count = errors;

    function automatic timer_result_t make_result(status_t st, logic [ID_BITS-1:0] id,
                                                  logic lst);
        timer_result_t r;
        r.status   = st;
        r.fired_id = '0;
        r.fired_id = M_TDATA_W'(id);
        r.last     = lst;
        return r;
    endfunction

    // Applies one transaction to the queue copy and queues up what it yields.
    task automatic predict_timer_queue(func_t func, logic [TICK_W-1:0] delay,
                                       logic [HID_W-1:0] hid);
        logic [TICK_W-1:0] due;
        int unsigned       pos;
        int                fired;
        timer_result_t     held;
        bit                have_held;
        case (func)
            FUNC_REGISTER:
            begin
                if (entries >= QUEUE_DEPTH)
                begin
                    expected_results.push_back(make_result(STATUS_FULL, '0, 1'b1));
                end
                else
                begin
                    due = tick_now + delay;
                    pos = 0;
                    // Equal deadlines keep arrival order: the new one goes behind them.
                    while (pos < entries && deadlines[pos] <= due)
                        pos++;
                    for (int i = entries; i > pos; i--)
                    begin
                        deadlines[i]   = deadlines[i-1];
                        handler_ids[i] = handler_ids[i-1];
                    end
                    deadlines[pos]   = due;
                    handler_ids[pos] = hid[ID_BITS-1:0];
                    entries++;
                    expected_results.push_back(make_result(STATUS_REGISTERED, '0, 1'b1));
                end
            end
            FUNC_TICK:
            begin
                tick_now  = tick_now + 1;
                fired     = 0;
                have_held = 1'b0;
                while (fired < MAX_RESULTS && entries > 0 && deadlines[0] <= tick_now)
                begin
                    if (have_held)
                        expected_results.push_back(held);
                    held      = make_result(STATUS_FIRED, handler_ids[0], 1'b0);
                    have_held = 1'b1;
                    for (int i = 1; i < entries; i++)
                    begin
                        deadlines[i-1]   = deadlines[i];
                        handler_ids[i-1] = handler_ids[i];
                    end
                    entries--;
                    fired++;
                end
                if (entries == 0)
                    tick_now = '0;
                if (have_held)
                begin
                    held.last = 1'b1;
                    expected_results.push_back(held);
                end
                else
                begin
                    expected_results.push_back(make_result(STATUS_IDLE_TICK, '0, 1'b1));
                end
            end
            FUNC_CLEAR:
            begin
                entries = 0;
                expected_results.push_back(make_result(STATUS_CLEARED, '0, 1'b1));
            end
            default:
            begin
                // The reserved code is dropped by the block without a result.
            end
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        timer_result_t exp_r;
        if (!rst_n)
        begin
            expected_results.delete();
            tick_now = '0;
            entries  = 0;
            errors   = 0;
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                predict_timer_queue(s_tuser, s_tdata[TICK_W-1:0],
                                    s_tdata[TICK_W+HID_W-1:TICK_W]);
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $error("unexpected result: status %0d, fired_id %0d, last %0d",
                           m_tuser, m_tdata, m_tlast);
                    errors++;
                end
                else
                begin
                    exp_r = expected_results.pop_front();
                    if (m_tuser !== exp_r.status)
                    begin
                        $error("status: expected %0d, actual %0d", exp_r.status, m_tuser);
                        errors++;
                    end
                    if (m_tdata !== exp_r.fired_id)
                    begin
                        $error("fired_id: expected %0d, actual %0d", exp_r.fired_id, m_tdata);
                        errors++;
                    end
                    if (m_tlast !== exp_r.last)
                    begin
                        $error("last: expected %0d, actual %0d", exp_r.last, m_tlast);
                        errors++;
                    end
                end
            end
            pending <= expected_results.size();
        end
    end

endmodule

>>> tb/tick_deadline_queue_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tick deadline queue testbench
// Drives registrations, ticks and clears into the timer queue with random
// gaps and back-pressure; a checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tick_deadline_queue_core_tb;

    import tdq_pkg::*;

    localparam int RANDOM_ITEMS = 204;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 40;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [FUNC_W-1:0]    s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [STATUS_W-1:0]  m_tuser;
    logic                 m_tlast;
    int                   fail_count;
    int                   pending;

    bit gaps_on;
    bit hold_off_req;

    tick_deadline_queue_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    tick_deadline_queue_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    initial
    begin
        #5_000_000;
        $display("tick_deadline_queue_core_tb NOT OK");
        $finish;
    end

    // Result side: short random stalls, plus one long hold-off on request.
    initial
    begin
        int hold_cnt;
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_tready <= 1'b0;
                for (hold_cnt = 0; hold_cnt < HOLD_CYCLES; hold_cnt++)
                    @(negedge clk);
                hold_off_req = 1'b0;
                m_tready <= 1'b1;
            end
            else if (gaps_on && $urandom_range(0, 5) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
                m_tready <= 1'b1;
            end
            else
            begin
                m_tready <= 1'b1;
            end
        end
    end

    task automatic send_transaction(func_t func, logic [TICK_W-1:0] delay,
                                    logic [HID_W-1:0] hid);
        s_tvalid <= 1'b1;
        s_tuser  <= func;
        s_tdata  <= {hid, delay};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        @(negedge clk);
        if (gaps_on && $urandom_range(0, 3) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
        end
    endtask

    task automatic wait_results_drained();
        while (pending != 0)
            @(negedge clk);
    endtask

    // Mostly short delays so timers actually expire; now and then a full-range
    // delay that parks an entry until the next clear.
    task automatic send_random_transaction(output bit counted);
        int unsigned       pick;
        func_t             func;
        logic [TICK_W-1:0] delay;
        pick = $urandom_range(0, 99);
        if (pick < 46)
            func = FUNC_REGISTER;
        else if (pick < 90)
            func = FUNC_TICK;
        else if (pick < 96)
            func = FUNC_CLEAR;
        else
            func = FUNC_RSVD;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            delay = $urandom_range(0, 12);
        else if (pick < 85)
            delay = $urandom_range(0, 2000);
        else
            delay = $urandom;
        send_transaction(func, delay, HID_W'($urandom));
        counted = (func != FUNC_RSVD);
    endtask

    initial
    begin
        int random_count;
        int drain_cycles;
        bit counted;
        bit hold_done;
        bit pause_done;
        rst_n        = 1'b0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = FUNC_REGISTER;
        gaps_on      = 1'b1;
        hold_off_req = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Empty queue: idle tick, clear, and a reserved code that is ignored.
        send_transaction(FUNC_TICK, '0, '0);
        send_transaction(FUNC_CLEAR, '0, '0);
        send_transaction(FUNC_RSVD, 32'hFFFF_FFFF, 8'hFF);
        // Fill the queue (an early deadline, then fifteen equal ones), bounce one
        // off the full queue, then one tick fires all sixteen in arrival order.
        send_transaction(FUNC_REGISTER, 32'd0, 8'hFF);
        for (int k = 0; k < 15; k++)
            send_transaction(FUNC_REGISTER, 32'd1, HID_W'(k * 17));
        send_transaction(FUNC_REGISTER, 32'd5, 8'h77);
        send_transaction(FUNC_TICK, '0, '0);
        // A delay that wraps the 32-bit deadline fires on the very next tick.
        send_transaction(FUNC_REGISTER, 32'd5, 8'h11);
        send_transaction(FUNC_TICK, '0, '0);
        send_transaction(FUNC_REGISTER, 32'hFFFF_FFFF, 8'hA5);
        send_transaction(FUNC_TICK, '0, '0);
        send_transaction(FUNC_CLEAR, '0, '0);
        s_tvalid <= 1'b0;
        wait_results_drained();

        random_count = 0;
        hold_done    = 1'b0;
        pause_done   = 1'b0;
        while (random_count < RANDOM_ITEMS)
        begin
            if (!hold_done && random_count >= 80)
            begin
                hold_off_req = 1'b1;
                hold_done    = 1'b1;
            end
            if (!pause_done && random_count >= 140)
            begin
                s_tvalid <= 1'b0;
                wait_results_drained();
                pause_done = 1'b1;
            end
            if (random_count >= 170)
                gaps_on = 1'b0;
            if ($urandom_range(0, 29) == 0)
            begin
                // A burst of registrations to run the queue into its full state.
                repeat (18)
                    send_transaction(FUNC_REGISTER, $urandom_range(1, 6), HID_W'($urandom));
                random_count += 18;
            end
            else
            begin
                send_random_transaction(counted);
                if (counted)
                    random_count++;
            end
        end
        s_tvalid <= 1'b0;

        drain_cycles = 0;
        while (pending != 0 && drain_cycles < 20000)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (TAIL_CYCLES) @(negedge clk);
        if (fail_count == 0 && pending == 0)
        begin
            $display("tick_deadline_queue_core_tb OK");
        end
        else
        begin
            if (pending != 0)
                $error("%0d expected results never arrived", pending);
            $display("tick_deadline_queue_core_tb NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/tdq_pkg.sv
design/tick_deadline_queue_core.sv
design/tick_deadline_queue_core_checker.sv
tb/tick_deadline_queue_checker.sv
tb/tick_deadline_queue_core_tb.sv
